FILE: rtl/htq_pkg.sv
// ----------------------------------------------------------------------------
// htq_pkg
// Shared types and constants for the terrain height query unit.
// ----------------------------------------------------------------------------
package htq_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TERRAIN_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERRAIN_SIZE_Z = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z       = 3'd5;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [16:0] FRAC_ONE = 17'h10000;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] point_x;
        logic signed [31:0] point_z;
        logic [7:0]         sample_column;
        logic [7:0]         sample_row;
        logic [15:0]        sample_value;
    } req_t;

    typedef struct packed {
        logic               on_terrain;
        logic signed [31:0] height;
    } resp_t;

    // Request side-band carried alongside the axis pipelines
    typedef struct packed {
        logic        vld;
        logic        wr;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] value;
    } item_meta_t;

    typedef struct packed {
        logic vld;
        logic on;
    } pipe_ctl_t;

    typedef struct packed {
        logic        we;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] wdata;
    } mem_cmd_t;

    typedef struct packed {
        logic        vld;
        logic        on;
        logic        pc;
        logic        pr;
        logic [16:0] u;
        logic [16:0] v;
    } blend_in_t;

endpackage

FILE: rtl/heightmap_terrain_height_query_unit.sv
// ----------------------------------------------------------------------------
// heightmap_terrain_height_query_unit
// Heightmap store with pipelined barycentric height queries.
// ----------------------------------------------------------------------------
//  Channel  Signals                              Moves
//  request  req_valid / req_ready / req          query or sample write
//  response resp_valid / resp_ready / resp       on_terrain, height
//  config   cfg_we / cfg_index / cfg_data        register write, no wait
//
//  One request per cycle while the response is not stalled; the
//  cell/fraction divider resolves one bit per stage.
//  A stalled response freezes the whole pipeline; req_ready follows it.
//  Reset clears valid flags and loads register defaults; samples are
//  undefined until written.
// ----------------------------------------------------------------------------
module heightmap_terrain_height_query_unit #(
    parameter int GRID_POINTS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  htq_pkg::req_t                     req,
    output logic                              resp_valid,
    input  logic                              resp_ready,
    output htq_pkg::resp_t                    resp,
    input  logic                              cfg_we,
    input  logic [htq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);

    localparam int GW     = $clog2(GRID_POINTS);
    localparam int AX_LAT = GW + 18;

    logic               en;
    logic [31:0]        size_x_reg, size_z_reg, scale_reg;
    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;

    htq_pkg::item_meta_t meta_reg [0:AX_LAT-1];

    logic               on_x, on_z;
    logic [GW-1:0]      cell_x, cell_z;
    logic [16:0]        frac_x, frac_z;

    htq_pkg::mem_cmd_t  cmd;
    htq_pkg::item_meta_t mtail;
    logic [7:0]         c8, r8;
    logic [15:0]        rdata [0:3];
    htq_pkg::blend_in_t bin_reg, bin_next;
    htq_pkg::pipe_ctl_t bctl;
    logic [63:0]        product;

    logic signed [33:0] hsum;
    logic signed [31:0] hsat;
    logic               resp_valid_reg;
    htq_pkg::resp_t     resp_reg, resp_next;

    assign en        = !resp_valid_reg || resp_ready;
    assign req_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 32'h0100_0000;
            size_z_reg <= 32'h0100_0000;
            scale_reg  <= 32'h0001_0000;
            org_x_reg  <= '0;
            org_y_reg  <= '0;
            org_z_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                htq_pkg::CFG_TERRAIN_SIZE_X: size_x_reg <= cfg_data;
                htq_pkg::CFG_TERRAIN_SIZE_Z: size_z_reg <= cfg_data;
                htq_pkg::CFG_HEIGHT_SCALE:   scale_reg  <= cfg_data;
                htq_pkg::CFG_ORIGIN_X:       org_x_reg  <= cfg_data;
                htq_pkg::CFG_ORIGIN_Y:       org_y_reg  <= cfg_data;
                htq_pkg::CFG_ORIGIN_Z:       org_z_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AX_LAT; i++)
            begin
                meta_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            meta_reg[0] <= '{vld:   req_valid,
                             wr:    (req.opcode == htq_pkg::OP_WRITE),
                             col:   req.sample_column,
                             row:   req.sample_row,
                             value: req.sample_value};
            for (int i = 1; i < AX_LAT; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    htq_axis #(.GRID_POINTS(GRID_POINTS)) u_axis_x (
        .clk      (clk),
        .en       (en),
        .point    (req.point_x),
        .size     (size_x_reg),
        .origin   (org_x_reg),
        .on       (on_x),
        .cell_idx (cell_x),
        .frac     (frac_x)
    );

    htq_axis #(.GRID_POINTS(GRID_POINTS)) u_axis_z (
        .clk      (clk),
        .en       (en),
        .point    (req.point_z),
        .size     (size_z_reg),
        .origin   (org_z_reg),
        .on       (on_z),
        .cell_idx (cell_z),
        .frac     (frac_z)
    );

    // corner indices wrap at the 8-bit store address
    always_comb
    begin
        mtail     = meta_reg[AX_LAT-1];
        c8        = 8'(cell_x);
        r8        = 8'(cell_z);
        cmd.we    = mtail.vld && mtail.wr
                 && ({24'd0, mtail.col} < 32'(GRID_POINTS))
                 && ({24'd0, mtail.row} < 32'(GRID_POINTS));
        cmd.col   = mtail.col;
        cmd.row   = mtail.row;
        cmd.wdata = mtail.value;
        bin_next  = '{vld: mtail.vld,
                      on:  !mtail.wr && on_x && on_z,
                      pc:  c8[0],
                      pr:  r8[0],
                      u:   frac_x,
                      v:   frac_z};
    end

    htq_sample_mem u_mem (
        .clk   (clk),
        .en    (en),
        .cmd   (cmd),
        .cx    (c8),
        .cz    (r8),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg <= '0;
        end
        else if (en)
        begin
            bin_reg <= bin_next;
        end
    end

    htq_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .bin          (bin_reg),
        .rdata        (rdata),
        .height_scale (scale_reg),
        .ctl          (bctl),
        .product      (product)
    );

    always_comb
    begin
        hsum = $signed({2'b00, product[63:32]}) + {{2{org_y_reg[31]}}, org_y_reg};
        if (hsum[33:31] == 3'b000 || hsum[33:31] == 3'b111)
        begin
            hsat = hsum[31:0];
        end
        else if (hsum[33])
        begin
            hsat = 32'sh8000_0000;
        end
        else
        begin
            hsat = 32'sh7FFF_FFFF;
        end
        resp_next.on_terrain = bctl.on;
        resp_next.height     = bctl.on ? hsat : 32'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            resp_valid_reg <= bctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            resp_reg <= resp_next;
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

endmodule

FILE: rtl/htq_axis.sv
// ----------------------------------------------------------------------------
// htq_axis
// One axis: local offset, scaling by the grid span and a pipelined restoring
// divider giving cell index and 1.16 fraction.
// ----------------------------------------------------------------------------
module htq_axis #(
    parameter int GRID_POINTS = 256
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [31:0]                point,
    input  logic [31:0]                       size,
    input  logic signed [31:0]                origin,
    output logic                              on,
    output logic [$clog2(GRID_POINTS)-1:0]    cell_idx,
    output logic [16:0]                       frac
);

    localparam int GW = $clog2(GRID_POINTS);
    localparam int QB = GW + 16;
    localparam logic [GW-1:0] GRID_LAST = GW'(GRID_POINTS - 1);
    localparam logic [GW-1:0] CELL_MAX  = GW'(GRID_POINTS - 2);

    logic signed [33:0] l_reg;
    logic signed [33:0] l_next;
    logic               on_next;
    logic [31+GW:0]     t_next;

    logic [31:0]        rem_reg [0:QB-1];
    logic [QB-1:0]      low_reg [0:QB];
    logic               on_reg  [0:QB];

    logic [GW-1:0]      cell_raw;

    always_comb
    begin
        l_next = {{2{point[31]}}, point} + {2'b00, 1'b0, size[31:1]}
               - {{2{origin[31]}}, origin};
        on_next = (size != 32'd0) && !l_reg[33] && (l_reg <= $signed({2'b00, size}));
        t_next  = (32 + GW)'(l_reg[31:0]) * (32 + GW)'(GRID_LAST);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg      <= l_next;
            rem_reg[0] <= t_next[31+GW:GW];
            low_reg[0] <= {t_next[GW-1:0], 16'd0};
            on_reg[0]  <= on_next;
        end
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        logic [32:0] rs;
        logic        ge;

        always_comb
        begin
            rs = {rem_reg[i], low_reg[i][QB-1]};
            ge = (rs >= {1'b0, size});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                low_reg[i+1] <= {low_reg[i][QB-2:0], ge};
                on_reg[i+1]  <= on_reg[i];
            end
        end

        if (i < QB - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? 32'(rs - {1'b0, size}) : rs[31:0];
                end
            end
        end
    end

    always_comb
    begin
        cell_raw = low_reg[QB][QB-1:16];
        on       = on_reg[QB];
        if (cell_raw == GRID_LAST)
        begin
            cell_idx = CELL_MAX;
            frac     = htq_pkg::FRAC_ONE;
        end
        else
        begin
            cell_idx = cell_raw;
            frac     = {1'b0, low_reg[QB][15:0]};
        end
    end

endmodule

FILE: rtl/htq_sample_mem.sv
// ----------------------------------------------------------------------------
// htq_sample_mem
// Sample store in four banks split by row and column parity, so the four
// corners of a cell are read in the same cycle. One write port, registered reads.
// ----------------------------------------------------------------------------
module htq_sample_mem (
    input  logic              clk,
    input  logic              en,
    input  htq_pkg::mem_cmd_t cmd,
    input  logic [7:0]        cx,
    input  logic [7:0]        cz,
    output logic [15:0]       rdata [0:3]
);

    localparam int BANK_DEPTH = 16384;

    logic [1:0]  wbank;
    logic [13:0] waddr;

    assign wbank = {cmd.row[0], cmd.col[0]};
    assign waddr = {cmd.row[7:1], cmd.col[7:1]};

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [15:0] store [0:BANK_DEPTH-1];
        logic [7:0]  rcol;
        logic [7:0]  rrow;
        logic [13:0] raddr;

        always_comb
        begin
            rcol  = (cx[0] == 1'(b)) ? cx : cx + 8'd1;
            rrow  = (cz[0] == 1'(b >> 1)) ? cz : cz + 8'd1;
            raddr = {rrow[7:1], rcol[7:1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cmd.we && (wbank == 2'(b)))
                begin
                    store[waddr] <= cmd.wdata;
                end
                rdata[b] <= store[raddr];
            end
        end
    end

endmodule

FILE: rtl/htq_blend.sv
// ----------------------------------------------------------------------------
// htq_blend
// Triangle selection, barycentric blend of three corners and scaling by the
// full-scale height. Three register stages.
// ----------------------------------------------------------------------------
module htq_blend (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  htq_pkg::blend_in_t  bin,
    input  logic [15:0]         rdata [0:3],
    input  logic [31:0]         height_scale,
    output htq_pkg::pipe_ctl_t  ctl,
    output logic [63:0]         product
);

    htq_pkg::pipe_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;

    logic [15:0]        base_reg, base_next;
    logic signed [34:0] pa_reg, pa_next;
    logic signed [34:0] pb_reg, pb_next;
    logic [31:0]        s_reg, s_next;
    logic [63:0]        prod_reg;

    logic [15:0]        h00, h10, h01, h11;
    logic               left;
    logic signed [34:0] da, db, ma, mb;
    logic signed [35:0] sum;

    always_comb
    begin
        h00  = rdata[{bin.pr, bin.pc}];
        h10  = rdata[{bin.pr, ~bin.pc}];
        h01  = rdata[{~bin.pr, bin.pc}];
        h11  = rdata[{~bin.pr, ~bin.pc}];
        left = ({1'b0, bin.u} + {1'b0, bin.v}) <= {1'b0, htq_pkg::FRAC_ONE};
        if (left)
        begin
            base_next = h00;
            da = $signed({19'd0, h10}) - $signed({19'd0, h00});
            ma = $signed({18'd0, bin.u});
            db = $signed({19'd0, h01}) - $signed({19'd0, h00});
        end
        else
        begin
            base_next = h10;
            da = $signed({19'd0, h01}) - $signed({19'd0, h11});
            ma = $signed({18'd0, 17'(htq_pkg::FRAC_ONE - bin.u)});
            db = $signed({19'd0, h11}) - $signed({19'd0, h10});
        end
        mb      = $signed({18'd0, bin.v});
        pa_next = da * ma;
        pb_next = db * mb;

        sum = $signed({4'd0, base_reg, 16'd0}) + {pa_reg[34], pa_reg}
            + {pb_reg[34], pb_reg};
        s_next = sum[35] ? 32'd0 : sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= '{vld: bin.vld, on: bin.on};
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg <= base_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            s_reg    <= s_next;
            prod_reg <= 64'(s_reg) * 64'(height_scale);
        end
    end

    assign ctl     = ctl3_reg;
    assign product = prod_reg;

endmodule
